### design/pd_speed_drive_with_slew_limit_assert.svh
// assertion macros of the drive controller top level
`ifndef PD_SPEED_DRIVE_WITH_SLEW_LIMIT_ASSERT_SVH
`define PD_SPEED_DRIVE_WITH_SLEW_LIMIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PDSD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PDSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/pdsd_pkg.sv
// shared types and constants of the speed drive controller
`timescale 1ns / 1ps

package pdsd_pkg;

  localparam int SPEED_FRAC_BITS = 8;
  localparam int GAIN_FRAC_BITS  = 8;
  localparam int LEVEL_MAX       = 255;

  localparam int TARGET_W   = 12;
  localparam int MEASURED_W = 13;
  localparam int ERROR_W    = 14;
  localparam int LEVEL_W    = 8;
  localparam int GAIN_W     = 16;
  localparam int THRESH_W   = 12;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // fixed point of the gain products
  localparam int PROD_FRAC = SPEED_FRAC_BITS + GAIN_FRAC_BITS;

  localparam logic [LEVEL_W-1:0] DRIVE_STOP = LEVEL_W'(0);
  localparam logic [LEVEL_W-1:0] DRIVE_MIN  = LEVEL_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN         = 4'd0,
    CFG_DERIV_GAIN        = 4'd1,
    CFG_SLEW_STEP         = 4'd2,
    CFG_FEED_LOW          = 4'd3,
    CFG_FEED_MID          = 4'd4,
    CFG_FEED_HIGH         = 4'd5,
    CFG_SPEED_THRESH_LOW  = 4'd6,
    CFG_SPEED_THRESH_HIGH = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]   prop_gain;
    logic [GAIN_W-1:0]   deriv_gain;
    logic [LEVEL_W-1:0]  slew_step;
    logic [LEVEL_W-1:0]  feed_low;
    logic [LEVEL_W-1:0]  feed_mid;
    logic [LEVEL_W-1:0]  feed_high;
    logic [THRESH_W-1:0] speed_thresh_low;
    logic [THRESH_W-1:0] speed_thresh_high;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    prop_gain:         16'd2112,
    deriv_gain:        16'd2560,
    slew_step:         8'd10,
    feed_low:          8'd35,
    feed_mid:          8'd40,
    feed_high:         8'd60,
    speed_thresh_low:  12'd154,
    speed_thresh_high: 12'd307
  };

endpackage

### design/pd_speed_drive_with_slew_limit.sv
// top level of the pd speed drive controller with feedforward and slew limit
`timescale 1ns / 1ps
`include "pd_speed_drive_with_slew_limit_assert.svh"

// usage
//   input channel: one beat per control tick carries target_speed_i (unsigned)
//   and measured_speed_i (two's complement), both with 8 fraction bits
//   output channel: one beat per input beat carries drive_level_o
//   config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i at once;
//   indexes past the last register are dropped; write only while idle
// timing
//   a beat taken lands in the input register, the control law runs on it in
//   one combinational pass and the result is registered in the result
//   register once that slot is free; drive_level_o comes from that register
//   one beat per cycle sustained while out_ready_i is high; the stored level
//   and error close their loop in that single pass from input to result register
// reset
//   registers go to their defaults, stored level and error to zero, both
//   pipeline slots empty
// stall
//   a held result keeps its beat; one more beat waits in the input register,
//   then in_ready_o drops until the receiver takes the result
module pd_speed_drive_with_slew_limit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic        [pdsd_pkg::TARGET_W-1:0]   target_speed_i,
  input  logic signed [pdsd_pkg::MEASURED_W-1:0] measured_speed_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic        [pdsd_pkg::LEVEL_W-1:0]    drive_level_o,
  input  logic                                  cfg_we_i,
  input  logic        [pdsd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic        [pdsd_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import pdsd_pkg::*;

  cfg_t cfg;

  // input register slot
  logic                         s1_valid_q, s1_valid_d;
  logic        [TARGET_W-1:0]   s1_target_q;
  logic signed [MEASURED_W-1:0] s1_measured_q;

  // result register slot
  logic                         out_valid_q, out_valid_d;
  logic        [LEVEL_W-1:0]    out_drive_q;

  // loop state carried from tick to tick
  logic        [LEVEL_W-1:0]    prev_level_q, prev_level_d;
  logic signed [ERROR_W-1:0]    prev_error_q, prev_error_d;

  logic                         in_acc;
  logic                         advance;
  logic                         commit;
  logic        [LEVEL_W-1:0]    law_level;
  logic signed [ERROR_W-1:0]    law_error;
  logic        [LEVEL_W-1:0]    law_drive;

  pdsd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  pdsd_law u_law (
    .target_i     (s1_target_q),
    .measured_i   (s1_measured_q),
    .cfg_i        (cfg),
    .prev_level_i (prev_level_q),
    .prev_error_i (prev_error_q),
    .level_o      (law_level),
    .error_o      (law_error),
    .drive_o      (law_drive)
  );

  // result slot frees up when empty or taken this cycle
  assign advance    = !out_valid_q || out_ready_i;
  assign commit     = advance && s1_valid_q;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d   = s1_valid_q;
    out_valid_d  = out_valid_q;
    prev_level_d = prev_level_q;
    prev_error_d = prev_error_q;
    if (advance) begin
      out_valid_d = s1_valid_q;
      s1_valid_d  = 1'b0;
    end
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end
    // state moves only when a tick is handed to the result register
    if (commit) begin
      prev_level_d = law_level;
      prev_error_d = law_error;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      prev_level_q <= '0;
      prev_error_q <= '0;
    end else begin
      s1_valid_q   <= s1_valid_d;
      out_valid_q  <= out_valid_d;
      prev_level_q <= prev_level_d;
      prev_error_q <= prev_error_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_target_q   <= target_speed_i;
      s1_measured_q <= measured_speed_i;
    end
    if (commit) begin
      out_drive_q <= law_drive;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_level_o = out_drive_q;

  // input only blocks when both slots are full and the result is stalled
  `PDSD_ASSERT_IMPL(a_ready_blocks, !in_ready_o, s1_valid_q && out_valid_q && !out_ready_i, "ready low without a full stalled pipe")

  // a plain level shown on the output is the stored level
  `PDSD_ASSERT_IMPL(a_level_matches_state, out_valid_q && (out_drive_q > DRIVE_MIN), out_drive_q == prev_level_q, "drive level differs from stored level")

  // stored level moves by at most one slew step per tick
  `PDSD_ASSERT_NEXT(a_slew_up, commit, {1'b0, prev_level_q} <= {1'b0, $past(prev_level_q)} + {1'b0, $past(cfg.slew_step)}, "level rose past slew step")
  `PDSD_ASSERT_NEXT(a_slew_down, commit, {1'b0, $past(prev_level_q)} <= {1'b0, prev_level_q} + {1'b0, $past(cfg.slew_step)}, "level fell past slew step")

  // loop state holds when no tick is handed on
  `PDSD_ASSERT_NEXT(a_state_holds, !commit, $stable(prev_level_q) && $stable(prev_error_q), "loop state changed without a tick")

endmodule

### design/pdsd_cfg_regs.sv
// configuration register bank of the speed drive controller
`timescale 1ns / 1ps

module pdsd_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pdsd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pdsd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output pdsd_pkg::cfg_t                      cfg_o
);
  import pdsd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROP_GAIN:         cfg_d.prop_gain         = cfg_wdata_i[GAIN_W-1:0];
        CFG_DERIV_GAIN:        cfg_d.deriv_gain        = cfg_wdata_i[GAIN_W-1:0];
        CFG_SLEW_STEP:         cfg_d.slew_step         = cfg_wdata_i[LEVEL_W-1:0];
        CFG_FEED_LOW:          cfg_d.feed_low          = cfg_wdata_i[LEVEL_W-1:0];
        CFG_FEED_MID:          cfg_d.feed_mid          = cfg_wdata_i[LEVEL_W-1:0];
        CFG_FEED_HIGH:         cfg_d.feed_high         = cfg_wdata_i[LEVEL_W-1:0];
        CFG_SPEED_THRESH_LOW:  cfg_d.speed_thresh_low  = cfg_wdata_i[THRESH_W-1:0];
        CFG_SPEED_THRESH_HIGH: cfg_d.speed_thresh_high = cfg_wdata_i[THRESH_W-1:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/pdsd_law.sv
// control law: pd terms, feedforward, slew window, clamp and drive decision
`timescale 1ns / 1ps

module pdsd_law (
  input  logic        [pdsd_pkg::TARGET_W-1:0]   target_i,
  input  logic signed [pdsd_pkg::MEASURED_W-1:0] measured_i,
  input  pdsd_pkg::cfg_t                         cfg_i,
  input  logic        [pdsd_pkg::LEVEL_W-1:0]    prev_level_i,
  input  logic signed [pdsd_pkg::ERROR_W-1:0]    prev_error_i,
  output logic        [pdsd_pkg::LEVEL_W-1:0]    level_o,
  output logic signed [pdsd_pkg::ERROR_W-1:0]    error_o,
  output logic        [pdsd_pkg::LEVEL_W-1:0]    drive_o
);
  import pdsd_pkg::*;

  localparam int DERR_W  = ERROR_W + 1;
  localparam int PROP_W  = ERROR_W + GAIN_W + 1;
  localparam int DPROD_W = DERR_W + GAIN_W + 1;
  localparam int SUM_W   = DPROD_W + 2;
  localparam int LVL_W   = SUM_W - PROD_FRAC;
  localparam int WIN_W   = LEVEL_W + 2;
  localparam int UNIT    = 1 << SPEED_FRAC_BITS;
  localparam logic signed [LVL_W-1:0] LvlMax = LVL_W'(LEVEL_MAX);

  logic signed [ERROR_W-1:0] err;
  logic signed [DERR_W-1:0]  derr;
  logic signed [PROP_W-1:0]  prod_p;
  logic signed [DPROD_W-1:0] prod_d;
  logic        [LEVEL_W-1:0] feed;
  logic signed [SUM_W-1:0]   sum;
  logic signed [LVL_W-1:0]   lvl_raw, lvl_win, lvl_clip;
  logic signed [WIN_W-1:0]   win_lo, win_hi;
  logic signed [ERROR_W:0]   err_x2;
  logic signed [ERROR_W+3:0] err_x10;

  assign err  = $signed({2'b00, target_i}) - $signed({measured_i[MEASURED_W-1], measured_i});
  assign derr = $signed({err[ERROR_W-1], err})
              - $signed({prev_error_i[ERROR_W-1], prev_error_i});

  assign prod_p = err * $signed({1'b0, cfg_i.prop_gain});
  assign prod_d = derr * $signed({1'b0, cfg_i.deriv_gain});

  // thresholds tested in order, also when swapped
  always_comb begin
    priority if (target_i < cfg_i.speed_thresh_low) begin
      feed = cfg_i.feed_low;
    end else if (target_i < cfg_i.speed_thresh_high) begin
      feed = cfg_i.feed_mid;
    end else begin
      feed = cfg_i.feed_high;
    end
  end

  assign sum = $signed({{(SUM_W-PROP_W){prod_p[PROP_W-1]}}, prod_p})
             + $signed({{(SUM_W-DPROD_W){prod_d[DPROD_W-1]}}, prod_d})
             + $signed(SUM_W'(feed) << PROD_FRAC);

  // dropping the fraction bits of a two's complement value floors it
  assign lvl_raw = sum[SUM_W-1:PROD_FRAC];

  assign win_lo = $signed({2'b00, prev_level_i}) - $signed({2'b00, cfg_i.slew_step});
  assign win_hi = $signed({2'b00, prev_level_i}) + $signed({2'b00, cfg_i.slew_step});

  always_comb begin
    lvl_win = lvl_raw;
    if (lvl_win > LVL_W'(win_hi)) lvl_win = LVL_W'(win_hi);
    if (lvl_win < LVL_W'(win_lo)) lvl_win = LVL_W'(win_lo);
    lvl_clip = lvl_win;
    if (lvl_clip > LvlMax) lvl_clip = LvlMax;
    if (lvl_clip < 0) lvl_clip = '0;
  end

  assign err_x2  = {err, 1'b0};
  assign err_x10 = err * $signed(5'sd10);

  always_comb begin
    priority if ((err_x2 < -UNIT) || (target_i == '0)) begin
      drive_o = DRIVE_STOP;
    end else if (err_x10 < -UNIT) begin
      drive_o = DRIVE_MIN;
    end else begin
      drive_o = lvl_clip[LEVEL_W-1:0];
    end
  end

  assign level_o = lvl_clip[LEVEL_W-1:0];
  assign error_o = err;

endmodule

### dv/tb_pd_speed_drive_with_slew_limit.sv
// self-checking testbench of the pd speed drive controller with feedforward and slew limit
`timescale 1ns / 1ps

module tb_pd_speed_drive_with_slew_limit;
  import pdsd_pkg::*;

  // result register is loaded from the input register; the settle wait lets
  // the pipe empty after the last drive level is checked
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;
  // receiver hold-off long enough to fill both slots and stall the input
  localparam int LONG_HOLD     = 150;
  // cycles with no beat on either side before the run is declared hung
  localparam int STUCK_LIMIT   = 1000;

  typedef struct {
    logic        [TARGET_W-1:0]   target;
    logic signed [MEASURED_W-1:0] measured;
  } tick_t;

  logic                         clk_i            = 1'b0;
  logic                         rst_ni           = 1'b0;
  logic                         in_valid_i       = 1'b0;
  logic                         in_ready_o;
  logic        [TARGET_W-1:0]   target_speed_i   = '0;
  logic signed [MEASURED_W-1:0] measured_speed_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i      = 1'b0;
  logic        [LEVEL_W-1:0]    drive_level_o;
  logic                         cfg_we_i         = 1'b0;
  logic        [CFG_IDX_W-1:0]  cfg_idx_i        = '0;
  logic        [CFG_DATA_W-1:0] cfg_wdata_i      = '0;

  pd_speed_drive_with_slew_limit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .target_speed_i   (target_speed_i),
    .measured_speed_i (measured_speed_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .drive_level_o    (drive_level_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  // 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ticks waiting to be driven, and drive levels waiting to come out
  tick_t             tick_queue[$];
  logic [LEVEL_W-1:0] level_expect[$];

  int beats_queued   = 0;  // ticks handed to the driver so far
  int levels_checked = 0;  // output beats seen so far
  int mismatches     = 0;
  int stuck_cycles   = 0;

  bit in_took    = 1'b0;   // input beat accepted at the last rising edge
  bit quiet_tail = 1'b0;   // no idling on either side from here on
  int send_gap   = 0;
  int recv_gap   = 0;
  int hold_left  = 0;
  int holds_asked  = 0;
  int holds_served = 0;

  // controller copy: registers, stored level and stored error
  cfg_t                      law_cfg    = CFG_RESET;
  logic        [LEVEL_W-1:0] held_level = '0;
  logic signed [ERROR_W-1:0] held_error = '0;

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  // one control tick: pd law plus feedforward, slew window, range clamp,
  // then the stop and minimum overrides; updates the stored level and error
  function automatic logic [LEVEL_W-1:0] next_drive_level(
    input logic        [TARGET_W-1:0]   tgt,
    input logic signed [MEASURED_W-1:0] meas
  );
    longint err, feed, sum, lvl, lo, hi, unit_step;
    logic [LEVEL_W-1:0] cmd;
    err = longint'(tgt) - longint'(meas);
    // thresholds tested in order, even when high <= low
    if (tgt < law_cfg.speed_thresh_low) feed = longint'(law_cfg.feed_low);
    else if (tgt < law_cfg.speed_thresh_high) feed = longint'(law_cfg.feed_mid);
    else feed = longint'(law_cfg.feed_high);
    sum = err * longint'(law_cfg.prop_gain)
        + (err - longint'(held_error)) * longint'(law_cfg.deriv_gain)
        + (feed <<< PROD_FRAC);
    lvl = sum >>> PROD_FRAC;  // floor to whole counts
    // slew window first, then the output range
    lo = longint'(held_level) - longint'(law_cfg.slew_step);
    hi = longint'(held_level) + longint'(law_cfg.slew_step);
    if (lvl > hi) lvl = hi;
    if (lvl < lo) lvl = lo;
    if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
    if (lvl < 0) lvl = 0;
    held_level = LEVEL_W'(lvl);
    held_error = ERROR_W'(err);
    unit_step = longint'(1) <<< SPEED_FRAC_BITS;
    // hard stop below -0.5 m/s or at zero target, minimum below -0.1 m/s
    if (2 * err < -unit_step || tgt == '0) cmd = DRIVE_STOP;
    else if (10 * err < -unit_step) cmd = DRIVE_MIN;
    else cmd = LEVEL_W'(lvl);
    return cmd;
  endfunction

  // sender: holds a beat until taken, idles in random bursts
  always @(negedge clk_i) begin : drive_ticks
    tick_t beat;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_took) begin
      if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (tick_queue.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        in_valid_i <= 1'b0;
        send_gap   <= $urandom_range(0, 18);
      end else begin
        beat             = tick_queue.pop_front();
        in_valid_i       <= 1'b1;
        target_speed_i   <= beat.target;
        measured_speed_i <= beat.measured;
      end
    end
  end

  // receiver: random stall bursts, plus a long hold-off when asked
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_ready_i  <= 1'b0;
      hold_left    <= LONG_HOLD - 1;
      holds_served <= holds_served + 1;
    end else if (recv_gap != 0) begin
      out_ready_i <= 1'b0;
      recv_gap    <= recv_gap - 1;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      out_ready_i <= 1'b0;
      recv_gap    <= $urandom_range(0, 18);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor: follows register writes, predicts on input beats and checks
  // output beats against the oldest prediction
  always @(posedge clk_i) begin : watch_beats
    logic [LEVEL_W-1:0] want;
    if (!rst_ni) begin
      in_took    <= 1'b0;
      law_cfg    = CFG_RESET;
      held_level = '0;
      held_error = '0;
      level_expect.delete();
    end else begin
      in_took <= in_valid_i && in_ready_o;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PROP_GAIN:         law_cfg.prop_gain         = cfg_wdata_i;
          CFG_DERIV_GAIN:        law_cfg.deriv_gain        = cfg_wdata_i;
          CFG_SLEW_STEP:         law_cfg.slew_step         = cfg_wdata_i[LEVEL_W-1:0];
          CFG_FEED_LOW:          law_cfg.feed_low          = cfg_wdata_i[LEVEL_W-1:0];
          CFG_FEED_MID:          law_cfg.feed_mid          = cfg_wdata_i[LEVEL_W-1:0];
          CFG_FEED_HIGH:         law_cfg.feed_high         = cfg_wdata_i[LEVEL_W-1:0];
          CFG_SPEED_THRESH_LOW:  law_cfg.speed_thresh_low  = cfg_wdata_i[THRESH_W-1:0];
          CFG_SPEED_THRESH_HIGH: law_cfg.speed_thresh_high = cfg_wdata_i[THRESH_W-1:0];
          default: ;  // unused index, dropped
        endcase
      end
      if (in_valid_i && in_ready_o)
        level_expect = {level_expect, next_drive_level(target_speed_i, measured_speed_i)};
      if (out_valid_o && out_ready_i) begin
        levels_checked++;
        if (level_expect.size() == 0) begin
          flag_mismatch($sformatf("drive level %0d with nothing expected", drive_level_o));
        end else begin
          want = level_expect.pop_front();
          if (drive_level_o !== want)
            flag_mismatch($sformatf("drive level %0d, expected %0d", drive_level_o, want));
        end
      end
    end
  end

  // hang detection: cycles without a beat on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STUCK_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic queue_tick(input int tgt, input int meas);
    tick_t t;
    t.target   = TARGET_W'(tgt);
    t.measured = MEASURED_W'(meas);
    tick_queue = {tick_queue, t};
    beats_queued++;
  endtask

  // mostly measured speed near target so the pd path and the overspeed
  // band get exercised; the rest spans the whole field range
  task automatic queue_random_ticks(input int count);
    int pick, tgt, meas;
    repeat (count) begin
      pick = $urandom_range(0, 15);
      tgt  = (pick == 0) ? 0 : $urandom_range(1, 4095);
      if (pick < 4) begin
        meas = int'($signed(MEASURED_W'($urandom)));
      end else begin
        if (pick < 10) meas = tgt + $urandom_range(0, 600) - 300;
        else meas = tgt + $urandom_range(0, 80) - 40;
        if (meas > 4095) meas = 4095;
        if (meas < -4096) meas = -4096;
      end
      queue_tick(tgt, meas);
    end
  endtask

  // waits for every queued tick to come back, then lets the pipe empty
  task automatic wait_drained();
    while (levels_checked < beats_queued) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
  endtask

  // all eight registers; unused upper data bits carry noise
  task automatic program_regs(input cfg_t c);
    write_reg(CFG_PROP_GAIN,         c.prop_gain);
    write_reg(CFG_DERIV_GAIN,        c.deriv_gain);
    write_reg(CFG_SLEW_STEP,         {8'($urandom), c.slew_step});
    write_reg(CFG_FEED_LOW,          {8'($urandom), c.feed_low});
    write_reg(CFG_FEED_MID,          {8'($urandom), c.feed_mid});
    write_reg(CFG_FEED_HIGH,         {8'($urandom), c.feed_high});
    write_reg(CFG_SPEED_THRESH_LOW,  {4'($urandom), c.speed_thresh_low});
    write_reg(CFG_SPEED_THRESH_HIGH, {4'($urandom), c.speed_thresh_high});
    cfg_we_i <= 1'b0;
  endtask

  function automatic cfg_t random_regs();
    cfg_t c;
    c.prop_gain         = GAIN_W'($urandom_range(0, 4095));
    c.deriv_gain        = GAIN_W'($urandom_range(0, 4095));
    c.slew_step         = LEVEL_W'($urandom_range(0, 255));
    c.feed_low          = LEVEL_W'($urandom);
    c.feed_mid          = LEVEL_W'($urandom);
    c.feed_high         = LEVEL_W'($urandom);
    c.speed_thresh_low  = THRESH_W'($urandom);
    c.speed_thresh_high = THRESH_W'($urandom);
    return c;
  endfunction

  initial begin : stimulus
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // reset settings: zero target, field extremes, stop and minimum edges, threshold edges
    queue_tick(0, 0);          // zero target stops
    queue_tick(4095, -4096);   // largest error, slews up
    queue_tick(4095, -4096);
    queue_tick(4095, 4095);    // zero error, derivative pulls down
    queue_tick(1, 4095);       // deep overspeed stops
    queue_tick(256, 384);      // error exactly -0.5 m/s: minimum
    queue_tick(256, 385);      // just past -0.5 m/s: stop
    queue_tick(256, 281);      // error just above -0.1 m/s: level
    queue_tick(256, 282);      // just past -0.1 m/s: minimum
    queue_tick(153, 100);      // around the low threshold
    queue_tick(154, 100);
    queue_tick(306, 250);      // around the high threshold
    queue_tick(307, 250);
    queue_tick(0, -4096);      // zero target wins over positive error
    queue_random_ticks(400);
    wait_drained();

    // every register at its top value
    program_regs('{prop_gain: '1, deriv_gain: '1, slew_step: '1, feed_low: '1,
                   feed_mid: '1, feed_high: '1, speed_thresh_low: '1,
                   speed_thresh_high: '1});
    queue_tick(4095, -4096);
    queue_tick(4095, 4095);
    queue_tick(1, -4096);
    queue_tick(4094, 4000);
    queue_random_ticks(250);
    wait_drained();

    // every register at zero: no slew allowed, level frozen
    program_regs('0);
    queue_tick(2048, 0);
    queue_tick(4095, -4096);
    queue_random_ticks(150);
    wait_drained();

    // swapped thresholds, writes to unused indexes, long receiver hold-off
    write_reg(CFG_IDX_W'(CFG_SPEED_THRESH_HIGH) + 1'b1, 16'($urandom));
    write_reg(CFG_IDX_W'(CFG_SPEED_THRESH_HIGH) + CFG_IDX_W'($urandom_range(1, 8)),
              16'($urandom));
    program_regs('{prop_gain: 16'd2112, deriv_gain: 16'd2560, slew_step: 8'd40,
                   feed_low: 8'd20, feed_mid: 8'd90, feed_high: 8'd200,
                   speed_thresh_low: 12'd1000, speed_thresh_high: 12'd300});
    holds_asked++;
    queue_random_ticks(300);
    wait_drained();

    repeat (3) begin
      program_regs(random_regs());
      queue_random_ticks(250);
      wait_drained();
    end

    // back to defaults, both sides at full rate
    program_regs(CFG_RESET);
    quiet_tail <= 1'b1;
    queue_random_ticks(250);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (level_expect.size() != 0)
      flag_mismatch($sformatf("%0d expected drive levels never came", level_expect.size()));
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
